>>> rtl/core/i6i4_pkg.sv
// ----------------------------------------------------------------------------
// i6i4_pkg
// Shared types, message codes and the parameter problem pointer table for the
// ICMPv6 to ICMPv4 header map.
// ----------------------------------------------------------------------------
package i6i4_pkg;

  // icmpv6 types
  localparam logic [7:0] V6_DEST_UNREACH = 8'd1;
  localparam logic [7:0] V6_PKT_TOO_BIG  = 8'd2;
  localparam logic [7:0] V6_TIME_EXCEED  = 8'd3;
  localparam logic [7:0] V6_PARAM_PROB   = 8'd4;
  localparam logic [7:0] V6_ECHO_REQ     = 8'd128;
  localparam logic [7:0] V6_ECHO_REPLY   = 8'd129;

  // icmpv6 destination unreachable codes
  localparam logic [7:0] V6_UNR_NO_ROUTE     = 8'd0;
  localparam logic [7:0] V6_UNR_ADMIN        = 8'd1;
  localparam logic [7:0] V6_UNR_BEYOND_SCOPE = 8'd2;
  localparam logic [7:0] V6_UNR_ADDR         = 8'd3;
  localparam logic [7:0] V6_UNR_PORT         = 8'd4;

  // icmpv6 parameter problem codes
  localparam logic [7:0] V6_PP_FIELD     = 8'd0;
  localparam logic [7:0] V6_PP_NEXT_HDR  = 8'd1;

  // icmpv4 types
  localparam logic [7:0] V4_ECHO_REPLY   = 8'd0;
  localparam logic [7:0] V4_DEST_UNREACH = 8'd3;
  localparam logic [7:0] V4_ECHO_REQ     = 8'd8;
  localparam logic [7:0] V4_TIME_EXCEED  = 8'd11;
  localparam logic [7:0] V4_PARAM_PROB   = 8'd12;

  // icmpv4 unreachable codes
  localparam logic [7:0] V4_CODE_HOST    = 8'd1;
  localparam logic [7:0] V4_CODE_PROTO   = 8'd2;
  localparam logic [7:0] V4_CODE_PORT    = 8'd3;
  localparam logic [7:0] V4_CODE_FRAG    = 8'd4;
  localparam logic [7:0] V4_CODE_ADMIN   = 8'd10;
  localparam logic [7:0] V4_CODE_ZERO    = 8'd0;

  // ipv6 header overhead beyond ipv4
  localparam logic [31:0] HDR_DELTA = 32'd20;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_BAD_CODE = 2'd2,
    ST_BAD_PTR  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REST_ZERO = 2'd0,
    REST_ECHO = 2'd1,
    REST_MTU  = 2'd2,
    REST_PTR  = 2'd3
  } rest_kind_t;

  typedef struct packed {
    logic [7:0] v4_type;
    logic [7:0] v4_code;
    rest_kind_t rest_kind;
    logic [7:0] ptr;
    status_t    status;
    logic       inner;
  } dec_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ptr;
  } ptr_map_t;

  // rfc pointer table, ipv6 header offset -> ipv4 header offset
  function automatic ptr_map_t map_pointer(input logic [31:0] p);
    ptr_map_t r;
    r.hit = 1'b1;
    r.ptr = 8'd0;
    if (p > 32'd39) begin
      r.hit = 1'b0;
    end else if (p >= 32'd24) begin
      r.ptr = 8'd16;
    end else if (p >= 32'd8) begin
      r.ptr = 8'd12;
    end else begin
      case (p[2:0])
        3'd0: r.ptr = 8'd0;
        3'd1: r.ptr = 8'd1;
        3'd4, 3'd5: r.ptr = 8'd2;
        3'd6: r.ptr = 8'd9;
        3'd7: r.ptr = 8'd8;
        default: r.hit = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

>>> rtl/core/i6i4_decode.sv
// ----------------------------------------------------------------------------
// i6i4_decode
// Type and code decode: picks the ICMPv4 type and code, the kind of rest word,
// the mapped pointer, the status and the inner packet flag.
// ----------------------------------------------------------------------------
module i6i4_decode
  import i6i4_pkg::*;
(
  input  logic [7:0]  v6_type,
  input  logic [7:0]  v6_code,
  input  logic [31:0] v6_word,
  output dec_t        dec
);

  ptr_map_t pm;

  assign pm = map_pointer(v6_word);

  always_comb begin
    dec           = '0;
    dec.rest_kind = REST_ZERO;
    dec.status    = ST_OK;
    unique case (v6_type)
      V6_ECHO_REQ: begin
        dec.v4_type   = V4_ECHO_REQ;
        dec.rest_kind = REST_ECHO;
      end
      V6_ECHO_REPLY: begin
        dec.v4_type   = V4_ECHO_REPLY;
        dec.rest_kind = REST_ECHO;
      end
      V6_DEST_UNREACH: begin
        dec.v4_type = V4_DEST_UNREACH;
        dec.inner   = 1'b1;
        case (v6_code) inside
          V6_UNR_NO_ROUTE, V6_UNR_BEYOND_SCOPE, V6_UNR_ADDR: dec.v4_code = V4_CODE_HOST;
          V6_UNR_ADMIN:     dec.v4_code = V4_CODE_ADMIN;
          V6_UNR_PORT:      dec.v4_code = V4_CODE_PORT;
          default:          dec.status  = ST_BAD_CODE;
        endcase
      end
      V6_PKT_TOO_BIG: begin
        dec.v4_type   = V4_DEST_UNREACH;
        dec.v4_code   = V4_CODE_FRAG;
        dec.rest_kind = REST_MTU;
        dec.inner     = 1'b1;
      end
      V6_TIME_EXCEED: begin
        dec.v4_type = V4_TIME_EXCEED;
        dec.v4_code = v6_code;
        dec.inner   = 1'b1;
      end
      V6_PARAM_PROB: begin
        dec.inner = 1'b1;
        if (v6_code == V6_PP_FIELD) begin
          if (pm.hit) begin
            dec.v4_type   = V4_PARAM_PROB;
            dec.v4_code   = V4_CODE_ZERO;
            dec.rest_kind = REST_PTR;
            dec.ptr       = pm.ptr;
          end else begin
            dec.status = ST_BAD_PTR;
          end
        end else if (v6_code == V6_PP_NEXT_HDR) begin
          dec.v4_type = V4_DEST_UNREACH;
          dec.v4_code = V4_CODE_PROTO;
        end else begin
          dec.status = ST_BAD_CODE;
        end
      end
      default: dec.status = ST_BAD_TYPE;
    endcase

    // any failure clears the translated header
    if (dec.status != ST_OK) begin
      dec.v4_type   = '0;
      dec.v4_code   = '0;
      dec.rest_kind = REST_ZERO;
      dec.ptr       = '0;
      dec.inner     = 1'b0;
    end
  end

endmodule

>>> rtl/core/icmpv6_to_icmpv4_header_map.sv
// ----------------------------------------------------------------------------
// icmpv6_to_icmpv4_header_map
// Translates one ICMPv6 header per cycle into the ICMPv4 type, code and rest
// of header word, with a status and an inner packet flag. Three register
// stages: decode and the two 20-byte subtractions, then the compare of the
// packet MTU against the outbound link MTU, then the compare against the
// inbound link MTU and assembly of the rest word into the output register.
// A new request is taken every cycle unless the output stalls with the stages
// full. Each stage has its own valid bit and advances when it is empty or the
// next stage can take its contents, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
module icmpv6_to_icmpv4_header_map
  import i6i4_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_v6_type,
  input  logic [7:0]  in_v6_code,
  input  logic [31:0] in_v6_word,
  input  logic [15:0] in_echo_seq,
  input  logic [15:0] in_echo_ident,
  input  logic [15:0] in_out_link_mtu,
  input  logic [31:0] in_in_link_mtu,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_v4_type,
  output logic [7:0]  out_v4_code,
  output logic [31:0] out_rest_word,
  output logic [1:0]  out_status,
  output logic        out_inner_follows
);

  dec_t        dec;

  // stage valids
  logic        v1_r, v2_r, v3_r;
  logic        v1_nxt, v2_nxt, v3_nxt;
  logic        adv1, adv2, adv3;

  // stage 1
  dec_t        s1_dec_r;
  logic [31:0] s1_pmtu_r;
  logic [15:0] s1_n6_r;
  logic [15:0] s1_omtu_r;
  logic [31:0] s1_echo_r;
  logic [31:0] pmtu;
  logic [31:0] n6_full;

  // stage 2
  dec_t        s2_dec_r;
  logic [15:0] s2_m1_r;
  logic [15:0] s2_n6_r;
  logic [31:0] s2_echo_r;
  logic [15:0] m1;

  // stage 3 / output
  logic [7:0]  s3_type_r;
  logic [7:0]  s3_code_r;
  logic [31:0] s3_rest_r;
  logic [1:0]  s3_status_r;
  logic        s3_inner_r;
  logic [15:0] mtu;
  logic [31:0] rest;

  i6i4_decode u_decode (
    .v6_type (in_v6_type),
    .v6_code (in_v6_code),
    .v6_word (in_v6_word),
    .dec     (dec)
  );

  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  assign v1_nxt = adv1 ? in_valid : v1_r;
  assign v2_nxt = adv2 ? v1_r : v2_r;
  assign v3_nxt = adv3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // wrapping subtractions of the ipv6 header overhead
  assign pmtu    = in_v6_word - HDR_DELTA;
  assign n6_full = in_in_link_mtu - HDR_DELTA;

  assign m1 = (s1_pmtu_r < {16'd0, s1_omtu_r}) ? s1_pmtu_r[15:0] : s1_omtu_r;

  assign mtu = (s2_n6_r < s2_m1_r) ? s2_n6_r : s2_m1_r;

  always_comb begin
    case (s2_dec_r.rest_kind)
      REST_ECHO: rest = s2_echo_r;
      REST_MTU:  rest = {16'd0, mtu};
      REST_PTR:  rest = {s2_dec_r.ptr, 24'd0};
      default:   rest = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_dec_r  <= dec;
      s1_pmtu_r <= pmtu;
      s1_n6_r   <= n6_full[15:0];
      s1_omtu_r <= in_out_link_mtu;
      s1_echo_r <= {in_echo_ident, in_echo_seq};
    end
    if (adv2) begin
      s2_dec_r  <= s1_dec_r;
      s2_m1_r   <= m1;
      s2_n6_r   <= s1_n6_r;
      s2_echo_r <= s1_echo_r;
    end
    if (adv3) begin
      s3_type_r   <= s2_dec_r.v4_type;
      s3_code_r   <= s2_dec_r.v4_code;
      s3_rest_r   <= rest;
      s3_status_r <= s2_dec_r.status;
      s3_inner_r  <= s2_dec_r.inner;
    end
  end

  assign out_valid         = v3_r;
  assign out_v4_type       = s3_type_r;
  assign out_v4_code       = s3_code_r;
  assign out_rest_word     = s3_rest_r;
  assign out_status        = s3_status_r;
  assign out_inner_follows = s3_inner_r;

`ifndef SYNTHESIS
  // a failed translation carries an all-zero header
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_v4_type == '0 && out_v4_code == '0 && out_rest_word == '0 &&
       !out_inner_follows))
    else $error("failed translation with nonzero header");

  // the translated mtu always fits the low half of the rest word
  a_mtu_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK && out_v4_type == V4_DEST_UNREACH &&
     out_v4_code == V4_CODE_FRAG) |-> (out_rest_word[31:16] == 16'd0))
    else $error("packet too big mtu wider than 16 bits");

  // an empty first stage never refuses a request
  a_s1_take: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_ready)
    else $error("empty first stage holds off requests");

  // every request passes the three stages to the output when nothing stalls
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("request lost in the pipeline");
`endif

endmodule

>>> dv/icmp_map_checker.sv
// ----------------------------------------------------------------------------
// icmp_map_checker
// Watches both channels of the ICMPv6 to ICMPv4 header map. Every accepted
// request is translated here into the expected ICMPv4 header, and every result
// is compared field by field with the oldest expected header. Also holds the
// ICMPv6 code and type names that only the stimulus uses.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package icmp_map_tb_pkg;

  // icmpv6 codes with no translation, or copied as they are
  localparam logic [7:0] V6_UNR_POLICY      = 8'd5;
  localparam logic [7:0] V6_TE_HOP_LIMIT    = 8'd0;
  localparam logic [7:0] V6_CODE_MAX        = 8'hFF;

  // types with no translation
  localparam logic [7:0] V6_TYPE_RSVD       = 8'd0;
  localparam logic [7:0] V6_TYPE_NEIGH_SOL  = 8'd135;
  localparam logic [7:0] V6_TYPE_EXPANSION  = 8'd255;

endpackage

module icmp_map_checker
  import i6i4_pkg::*;
  import icmp_map_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_v6_type,
  input  logic [7:0]  in_v6_code,
  input  logic [31:0] in_v6_word,
  input  logic [15:0] in_echo_seq,
  input  logic [15:0] in_echo_ident,
  input  logic [15:0] in_out_link_mtu,
  input  logic [31:0] in_in_link_mtu,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_v4_type,
  input  logic [7:0]  out_v4_code,
  input  logic [31:0] out_rest_word,
  input  logic [1:0]  out_status,
  input  logic        out_inner_follows,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [7:0]  v4_type;
    logic [7:0]  v4_code;
    logic [31:0] rest_word;
    status_t     status;
    logic        inner_follows;
  } v4_hdr_t;

  v4_hdr_t expected_hdrs[$];
  v4_hdr_t want;
  int      n_checked = 0;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic v4_hdr_t translate_header(input logic [7:0]  t,
                                               input logic [7:0]  c,
                                               input logic [31:0] word,
                                               input logic [15:0] seq,
                                               input logic [15:0] ident,
                                               input logic [15:0] omtu,
                                               input logic [31:0] imtu);
    v4_hdr_t     h;
    logic [31:0] pkt_mtu;
    logic [31:0] link_mtu;
    logic [31:0] mtu;
    logic [7:0]  ptr;
    logic        ptr_ok;
    h        = '0;
    h.status = ST_OK;

    // three-way minimum, subtractions wrap, inbound one cut to 16 bits
    pkt_mtu  = word - HDR_DELTA;
    link_mtu = imtu - HDR_DELTA;
    link_mtu = {16'd0, link_mtu[15:0]};
    mtu      = {16'd0, omtu};
    if (pkt_mtu < mtu) mtu = pkt_mtu;
    if (link_mtu < mtu) mtu = link_mtu;

    // ipv6 header offset to ipv4 header offset
    ptr_ok = 1'b1;
    ptr    = 8'd0;
    if (word > 32'd39) begin
      ptr_ok = 1'b0;
    end else if (word >= 32'd24) begin
      ptr = 8'd16;
    end else if (word >= 32'd8) begin
      ptr = 8'd12;
    end else begin
      case (word[2:0])
        3'd0: ptr = 8'd0;
        3'd1: ptr = 8'd1;
        3'd4, 3'd5: ptr = 8'd2;
        3'd6: ptr = 8'd9;
        3'd7: ptr = 8'd8;
        default: ptr_ok = 1'b0;
      endcase
    end

    case (t) inside
      V6_ECHO_REQ, V6_ECHO_REPLY: begin
        h.v4_type   = (t == V6_ECHO_REQ) ? V4_ECHO_REQ : V4_ECHO_REPLY;
        h.v4_code   = V4_CODE_ZERO;
        h.rest_word = {ident, seq};
      end
      V6_DEST_UNREACH: begin
        h.v4_type       = V4_DEST_UNREACH;
        h.inner_follows = 1'b1;
        case (c) inside
          V6_UNR_NO_ROUTE, V6_UNR_BEYOND_SCOPE, V6_UNR_ADDR: h.v4_code = V4_CODE_HOST;
          V6_UNR_ADMIN: h.v4_code = V4_CODE_ADMIN;
          V6_UNR_PORT: h.v4_code = V4_CODE_PORT;
          default: h.status = ST_BAD_CODE;
        endcase
      end
      V6_PKT_TOO_BIG: begin
        h.v4_type       = V4_DEST_UNREACH;
        h.v4_code       = V4_CODE_FRAG;
        h.rest_word     = {16'd0, mtu[15:0]};
        h.inner_follows = 1'b1;
      end
      V6_TIME_EXCEED: begin
        h.v4_type       = V4_TIME_EXCEED;
        h.v4_code       = c;
        h.inner_follows = 1'b1;
      end
      V6_PARAM_PROB: begin
        h.inner_follows = 1'b1;
        if (c == V6_PP_FIELD) begin
          if (ptr_ok) begin
            h.v4_type   = V4_PARAM_PROB;
            h.v4_code   = V4_CODE_ZERO;
            h.rest_word = {ptr, 24'd0};
          end else begin
            h.status = ST_BAD_PTR;
          end
        end else if (c == V6_PP_NEXT_HDR) begin
          h.v4_type = V4_DEST_UNREACH;
          h.v4_code = V4_CODE_PROTO;
        end else begin
          h.status = ST_BAD_CODE;
        end
      end
      default: h.status = ST_BAD_TYPE;
    endcase

    // any failure blanks the whole header
    if (h.status != ST_OK) begin
      h.v4_type       = 8'd0;
      h.v4_code       = 8'd0;
      h.rest_word     = 32'd0;
      h.inner_follows = 1'b0;
    end
    return h;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
             n_checked, field, got, exp_val);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_hdrs.push_back(translate_header(in_v6_type, in_v6_code, in_v6_word,
                                               in_echo_seq, in_echo_ident,
                                               in_out_link_mtu, in_in_link_mtu));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_hdrs.size() == 0) begin
        report_mismatch("result with no request", out_rest_word, 32'd0);
      end else begin
        want = expected_hdrs.pop_front();
        if (out_v4_type !== want.v4_type)
          report_mismatch("v4_type", 32'(out_v4_type), 32'(want.v4_type));
        if (out_v4_code !== want.v4_code)
          report_mismatch("v4_code", 32'(out_v4_code), 32'(want.v4_code));
        if (out_rest_word !== want.rest_word)
          report_mismatch("rest_word", out_rest_word, want.rest_word);
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_inner_follows !== want.inner_follows)
          report_mismatch("inner_follows", 32'(out_inner_follows),
                          32'(want.inner_follows));
      end
      n_checked++;
    end
    pending = expected_hdrs.size();
  end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the ICMPv6 to ICMPv4 header map bench. Sends a directed set of
// headers covering every type, code class, pointer range and MTU corner, then
// random headers with random gaps on the request side, random stalls on the
// result side, a stretch with neither, and one long result stall that backs
// the pipeline up. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
  import i6i4_pkg::*;
  import icmp_map_tb_pkg::*;
();

  localparam int IDLE_LIMIT   = 2000;
  localparam int N_RANDOM     = 425;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_v6_type;
  logic [7:0]  in_v6_code;
  logic [31:0] in_v6_word;
  logic [15:0] in_echo_seq;
  logic [15:0] in_echo_ident;
  logic [15:0] in_out_link_mtu;
  logic [31:0] in_in_link_mtu;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_v4_type;
  logic [7:0]  out_v4_code;
  logic [31:0] out_rest_word;
  logic [1:0]  out_status;
  logic        out_inner_follows;

  int errors;
  int pending;
  int n_sent      = 0;
  int idle_cycles = 0;
  bit stall_en    = 1'b1;

  icmpv6_to_icmpv4_header_map u_dut (.*);

  icmp_map_checker u_chk (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one request, with random gaps before it, and hold it until taken
  task automatic send_hdr(input logic [7:0] t, input logic [7:0] c,
                          input logic [31:0] word, input logic [15:0] seq,
                          input logic [15:0] ident, input logic [15:0] omtu,
                          input logic [31:0] imtu);
    while (stall_en && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_v6_type      <= t;
    in_v6_code      <= c;
    in_v6_word      <= word;
    in_echo_seq     <= seq;
    in_echo_ident   <= ident;
    in_out_link_mtu <= omtu;
    in_in_link_mtu  <= imtu;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0]  rt;
    logic [7:0]  rc;
    logic [31:0] rword;
    logic [31:0] rimtu;
    logic [15:0] romtu;
    int          pick;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_v6_type      = 8'd0;
    in_v6_code      = 8'd0;
    in_v6_word      = 32'd0;
    in_echo_seq     = 16'd0;
    in_echo_ident   = 16'd0;
    in_out_link_mtu = 16'd0;
    in_in_link_mtu  = 32'd0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // echo with extreme id and sequence
    send_hdr(V6_ECHO_REQ, V6_CODE_MAX, $urandom, 16'h0000, 16'hFFFF, 16'($urandom),
             $urandom);
    send_hdr(V6_ECHO_REPLY, 8'd0, $urandom, 16'hFFFF, 16'h0000, 16'($urandom),
             $urandom);
    // every unreachable code, listed and not
    send_hdr(V6_DEST_UNREACH, V6_UNR_NO_ROUTE, $urandom, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    send_hdr(V6_DEST_UNREACH, V6_UNR_ADMIN, $urandom, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    send_hdr(V6_DEST_UNREACH, V6_UNR_BEYOND_SCOPE, $urandom, 16'($urandom),
             16'($urandom), 16'($urandom), $urandom);
    send_hdr(V6_DEST_UNREACH, V6_UNR_ADDR, $urandom, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    send_hdr(V6_DEST_UNREACH, V6_UNR_PORT, $urandom, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    send_hdr(V6_DEST_UNREACH, V6_UNR_POLICY, $urandom, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    send_hdr(V6_DEST_UNREACH, V6_CODE_MAX, $urandom, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    // packet too big: each operand wins once, then wrapped subtractions
    send_hdr(V6_PKT_TOO_BIG, 8'd0, 32'd1300, 16'd0, 16'd0, 16'hFFFF, 32'd1500);
    send_hdr(V6_PKT_TOO_BIG, 8'd0, 32'hFFFFFFFF, 16'd0, 16'd0, 16'h0000, 32'hFFFFFFFF);
    send_hdr(V6_PKT_TOO_BIG, 8'd0, 32'd9000, 16'd0, 16'd0, 16'd9000, 32'h0001_0078);
    send_hdr(V6_PKT_TOO_BIG, V6_CODE_MAX, 32'd5, 16'd0, 16'd0, 16'd1280, 32'd10);
    // time exceeded copies any code
    send_hdr(V6_TIME_EXCEED, V6_CODE_MAX, $urandom, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    send_hdr(V6_TIME_EXCEED, V6_TE_HOP_LIMIT, $urandom, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    // parameter problem pointer table edges and holes
    send_hdr(V6_PARAM_PROB, V6_PP_FIELD, 32'd0, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    send_hdr(V6_PARAM_PROB, V6_PP_FIELD, 32'd3, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    send_hdr(V6_PARAM_PROB, V6_PP_FIELD, 32'd39, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    send_hdr(V6_PARAM_PROB, V6_PP_FIELD, 32'd40, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    send_hdr(V6_PARAM_PROB, V6_PP_FIELD, 32'hFFFFFFFF, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    send_hdr(V6_PARAM_PROB, V6_PP_FIELD, 32'd6, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    send_hdr(V6_PARAM_PROB, V6_PP_NEXT_HDR, $urandom, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    send_hdr(V6_PARAM_PROB, V6_CODE_MAX, 32'd0, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    // types with no translation
    send_hdr(V6_TYPE_RSVD, 8'd0, $urandom, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);
    send_hdr(V6_TYPE_EXPANSION, 8'd0, $urandom, 16'($urandom), 16'($urandom),
             16'($urandom), $urandom);

    for (int i = 0; i < N_RANDOM; i++) begin
      stall_en = !(i >= 150 && i < 260);
      pick = $urandom_range(99);
      if (pick < 12) rt = V6_ECHO_REQ;
      else if (pick < 24) rt = V6_ECHO_REPLY;
      else if (pick < 40) rt = V6_DEST_UNREACH;
      else if (pick < 56) rt = V6_PKT_TOO_BIG;
      else if (pick < 68) rt = V6_TIME_EXCEED;
      else if (pick < 88) rt = V6_PARAM_PROB;
      else if (pick < 92) rt = V6_TYPE_NEIGH_SOL;
      else rt = 8'($urandom);
      rc = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(5));
      case ($urandom_range(3))
        0: rword = $urandom;
        1: rword = $urandom_range(45);
        2: rword = $urandom_range(9100, 1300);
        default: rword = $urandom_range(30);
      endcase
      case ($urandom_range(3))
        0: rimtu = $urandom;
        1: rimtu = $urandom_range(30);
        default: rimtu = $urandom_range(9000, 1280);
      endcase
      romtu = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(9000, 576));
      send_hdr(rt, rc, rword, 16'($urandom), 16'($urandom), romtu, rimtu);
    end
    in_valid <= 1'b0;
    stall_en = 1'b1;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** icmpv6_to_icmpv4_header_map: PASSED **");
    end else begin
      $display("** icmpv6_to_icmpv4_header_map: FAILED **");
    end
    $finish;
  end

  // result side: random stalls, plus one long hold-off while requests keep coming
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && n_sent >= 320) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= !stall_en || ($urandom_range(99) >= 29);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("** icmpv6_to_icmpv4_header_map: FAILED **");
      $finish;
    end
  end

endmodule
